>>> sv/tias_pkg.sv
// tias_pkg: shared types, constants and the calibration rom of the aim solver
// no dependencies; imported by every module of the block
package tias_pkg;

    localparam int NUM_POINTS    = 22;
    localparam int FRAC_BITS_DEF = 16;
    localparam int IDX_W         = $clog2(NUM_POINTS);
    localparam int DIST_W        = 16;
    localparam int ELEV_W        = 13;
    localparam int VEL_W         = 13;
    localparam int HGT_W         = 16;
    localparam int GAIN_W        = 8;
    localparam int OUT_ELEV_W    = 21;
    localparam int HGT_SHIFT     = 4;
    localparam int MUL_A_W       = 17;
    localparam int PADDR_W       = 3;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd128;

    // register index within the config map
    localparam logic REG_HEIGHT_GAIN = 1'b0;

    localparam logic [1:0] STATUS_INTERP = 2'd0;
    localparam logic [1:0] STATUS_NEAR   = 2'd1;
    localparam logic [1:0] STATUS_FAR    = 2'd2;

    localparam logic [IDX_W-1:0] IDX_FIRST = '0;
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(NUM_POINTS - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MUL_ELEV,
        ST_MUL_VEL,
        ST_MUL_HGT,
        ST_FINISH,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic signed [OUT_ELEV_W-1:0] elev;
        logic [VEL_W-1:0]             vel;
        logic [1:0]                   status;
    } result_t;

    function automatic logic [DIST_W-1:0] rom_dist(input logic [IDX_W-1:0] idx);
        logic [DIST_W-1:0] d;
        case (idx)
            5'd0:    d = 16'd19184;
            5'd1:    d = 16'd21999;
            5'd2:    d = 16'd24023;
            5'd3:    d = 16'd25534;
            5'd4:    d = 16'd26582;
            5'd5:    d = 16'd27367;
            5'd6:    d = 16'd28336;
            5'd7:    d = 16'd28794;
            5'd8:    d = 16'd28966;
            5'd9:    d = 16'd31932;
            5'd10:   d = 16'd34449;
            5'd11:   d = 16'd36135;
            5'd12:   d = 16'd37989;
            5'd13:   d = 16'd38788;
            5'd14:   d = 16'd39052;
            5'd15:   d = 16'd42315;
            5'd16:   d = 16'd45131;
            5'd17:   d = 16'd47874;
            5'd18:   d = 16'd48886;
            5'd19:   d = 16'd49151;
            5'd20:   d = 16'd58892;
            5'd21:   d = 16'd59222;
            default: d = 16'd65535;
        endcase
        return d;
    endfunction

    function automatic logic signed [ELEV_W-1:0] rom_elev(input logic [IDX_W-1:0] idx);
        logic signed [ELEV_W-1:0] e;
        case (idx)
            5'd0:    e = -13'sd512;
            5'd1:    e = -13'sd768;
            5'd2:    e = -13'sd1024;
            5'd3:    e = -13'sd1280;
            5'd4:    e = -13'sd1536;
            5'd5:    e = -13'sd1792;
            5'd6:    e = -13'sd2304;
            5'd7:    e = -13'sd2816;
            5'd8:    e = -13'sd3328;
            5'd9:    e = -13'sd768;
            5'd10:   e = -13'sd1024;
            5'd11:   e = -13'sd1280;
            5'd12:   e = -13'sd1792;
            5'd13:   e = -13'sd2304;
            5'd14:   e = -13'sd2816;
            5'd15:   e = -13'sd768;
            5'd16:   e = -13'sd1024;
            5'd17:   e = -13'sd1536;
            5'd18:   e = -13'sd2048;
            5'd19:   e = -13'sd2560;
            5'd20:   e = -13'sd1792;
            5'd21:   e = -13'sd2304;
            default: e = '0;
        endcase
        return e;
    endfunction

    function automatic logic [VEL_W-1:0] rom_vel(input logic [IDX_W-1:0] idx);
        logic [VEL_W-1:0] v;
        case (idx)
            5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8:
                v = 13'd3840;
            5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14:
                v = 13'd5120;
            5'd15, 5'd16, 5'd17, 5'd18, 5'd19:
                v = 13'd6400;
            5'd20, 5'd21:
                v = 13'd7680;
            default:
                v = 13'd7680;
        endcase
        return v;
    endfunction

endpackage

>>> sv/tias_divider.sv
// tias_divider: restoring divider, one quotient bit per cycle
// dividend is below divisor, so the quotient is a pure fraction; uses tias_pkg
module tias_divider #(
    parameter int FRAC_BITS = tias_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tias_pkg::DIST_W-1:0] dividend,
    input  logic [tias_pkg::DIST_W-1:0] divisor,
    output logic                        busy,
    output logic [FRAC_BITS-1:0]        quotient
);
    import tias_pkg::*;

    localparam int CW = $clog2(FRAC_BITS + 1);

    logic              busy_reg, busy_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [DIST_W-1:0] rem_reg, rem_next;
    logic [DIST_W-1:0] div_reg;
    logic [FRAC_BITS-1:0] quo_reg, quo_next;
    logic [DIST_W:0]   shifted;
    logic [DIST_W:0]   diff;
    logic              fits;

    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, div_reg};
    assign fits    = shifted >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(FRAC_BITS);
            rem_next  = dividend;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIST_W-1:0] : shifted[DIST_W-1:0];
            quo_next = {quo_reg[FRAC_BITS-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

>>> sv/tias_mult.sv
// tias_mult: shared signed multiplier with a registered product
// used for both interpolation products and the height correction; uses tias_pkg
module tias_mult #(
    parameter int B_W = tias_pkg::FRAC_BITS_DEF + 1
) (
    input  logic                                clk,
    input  logic signed [tias_pkg::MUL_A_W-1:0] a,
    input  logic signed [B_W-1:0]               b,
    output logic signed [tias_pkg::MUL_A_W+B_W-1:0] prod
);
    import tias_pkg::*;

    logic signed [MUL_A_W+B_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

>>> sv/tias_seq.sv
// tias_seq: sequencer for clamp check, segment search, divide and the multiply steps
// depends on tias_pkg, tias_divider and tias_mult
module tias_seq #(
    parameter int FRAC_BITS = tias_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tias_pkg::DIST_W-1:0] target,
    input  logic signed [tias_pkg::HGT_W-1:0] height,
    input  logic [tias_pkg::GAIN_W-1:0] gain,
    output logic                        busy,
    output logic                        res_valid,
    input  logic                        res_ready,
    output tias_pkg::result_t           res
);
    import tias_pkg::*;

    localparam int B_W = FRAC_BITS + 1;
    localparam int P_W = MUL_A_W + B_W;

    seq_state_t state_reg, state_next;
    logic [IDX_W-1:0]      k_reg, k_next;
    logic [IDX_W-1:0]      k_lo;
    logic [DIST_W-1:0]     t_reg, t_next;
    logic signed [HGT_W-1:0] h_reg, h_next;
    logic signed [OUT_ELEV_W-1:0] elev_reg, elev_next;
    logic [VEL_W-1:0]      vel_reg, vel_next;
    logic [1:0]            status_reg, status_next;

    logic                  div_start;
    logic [DIST_W-1:0]     div_num;
    logic [DIST_W-1:0]     div_den;
    logic                  div_busy;
    logic [FRAC_BITS-1:0]  frac;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [B_W-1:0]     mul_b;
    logic signed [P_W-1:0]     prod;

    logic signed [ELEV_W:0] diff_elev;
    logic signed [VEL_W:0]  diff_vel;
    logic signed [B_W-1:0]  frac_s;
    logic signed [B_W-1:0]  gain_s;

    assign k_lo      = k_reg - IDX_W'(1);
    assign diff_elev = (ELEV_W+1)'(rom_elev(k_reg)) - (ELEV_W+1)'(rom_elev(k_lo));
    assign diff_vel  = $signed({1'b0, rom_vel(k_reg)}) - $signed({1'b0, rom_vel(k_lo)});
    assign frac_s    = $signed({1'b0, frac});
    assign gain_s    = $signed(B_W'({1'b0, gain}));
    assign div_num   = t_reg - rom_dist(k_lo);
    assign div_den   = rom_dist(k_reg) - rom_dist(k_lo);

    tias_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .quotient (frac)
    );

    tias_mult #(
        .B_W (B_W)
    ) u_mult (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        t_next      = t_reg;
        h_next      = h_reg;
        elev_next   = elev_reg;
        vel_next    = vel_reg;
        status_next = status_reg;
        div_start   = 1'b0;
        mul_a       = MUL_A_W'(diff_elev);
        mul_b       = frac_s;
        res_valid   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    t_next = target;
                    h_next = height;
                    k_next = IDX_W'(1);
                    if (target <= rom_dist(IDX_FIRST))
                    begin
                        elev_next   = OUT_ELEV_W'(rom_elev(IDX_FIRST));
                        vel_next    = rom_vel(IDX_FIRST);
                        status_next = STATUS_NEAR;
                        state_next  = ST_DONE;
                    end
                    else if (target >= rom_dist(IDX_LAST))
                    begin
                        elev_next   = OUT_ELEV_W'(rom_elev(IDX_LAST));
                        vel_next    = rom_vel(IDX_LAST);
                        status_next = STATUS_FAR;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        status_next = STATUS_INTERP;
                        state_next  = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (t_reg < rom_dist(k_reg))
                begin
                    state_next = ST_DIV_START;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (!div_busy)
                begin
                    state_next = ST_MUL_ELEV;
                end
            end
            ST_MUL_ELEV:
            begin
                mul_a      = MUL_A_W'(diff_elev);
                mul_b      = frac_s;
                state_next = ST_MUL_VEL;
            end
            ST_MUL_VEL:
            begin
                // floor shift is an arithmetic right shift
                elev_next  = OUT_ELEV_W'(rom_elev(k_lo)) + OUT_ELEV_W'(prod >>> FRAC_BITS);
                mul_a      = MUL_A_W'(diff_vel);
                mul_b      = frac_s;
                state_next = ST_MUL_HGT;
            end
            ST_MUL_HGT:
            begin
                vel_next   = rom_vel(k_lo) + VEL_W'(prod >>> FRAC_BITS);
                mul_a      = MUL_A_W'(h_reg);
                mul_b      = gain_s;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                elev_next  = elev_reg + OUT_ELEV_W'(prod >>> HGT_SHIFT);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        h_reg      <= h_next;
        elev_reg   <= elev_next;
        vel_reg    <= vel_next;
        status_reg <= status_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign res.elev   = elev_reg;
    assign res.vel    = vel_reg;
    assign res.status = status_reg;

endmodule

>>> sv/table_interpolated_aim_solver_core.sv
// table_interpolated_aim_solver_core: aim solver top level with config register
// and output register; depends on tias_pkg and tias_seq
// a clamped distance goes straight to the done state; otherwise the time to out_valid
// depends on k, the upper segment point, and is set by the serial search and the divider;
// one item at a time, input stalled until the result moves to the output register;
// reset: idle, empty, gain 128
module table_interpolated_aim_solver_core #(
    parameter int FRAC_BITS = tias_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tias_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [tias_pkg::DIST_W-1:0]         target_distance,
    input  logic signed [tias_pkg::HGT_W-1:0]   height_offset,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [tias_pkg::OUT_ELEV_W-1:0] aim_elevation,
    output logic [tias_pkg::VEL_W-1:0]          muzzle_velocity,
    output logic [1:0]                          range_status
);
    import tias_pkg::*;

    logic [GAIN_W-1:0] gain_reg;
    logic              cfg_write;
    logic              seq_busy;
    logic              seq_valid;
    logic              seq_ready;
    result_t           seq_res;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_HEIGHT_GAIN) ? 32'(gain_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_HEIGHT_GAIN))
        begin
            gain_reg <= pwdata[GAIN_W-1:0];
        end
    end

    tias_seq #(
        .FRAC_BITS (FRAC_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && !in_stall),
        .target    (target_distance),
        .height    (height_offset),
        .gain      (gain_reg),
        .busy      (seq_busy),
        .res_valid (seq_valid),
        .res_ready (seq_ready),
        .res       (seq_res)
    );

    assign in_stall  = seq_busy;
    assign seq_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (seq_valid && seq_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_valid && seq_ready)
        begin
            out_reg <= seq_res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign aim_elevation   = out_reg.elev;
    assign muzzle_velocity = out_reg.vel;
    assign range_status    = out_reg.status;

    // an accepted transfer keeps the input side stalled while it is worked on
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after transfer");

    a_near_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && range_status == STATUS_NEAR) |->
        (aim_elevation == OUT_ELEV_W'(rom_elev(IDX_FIRST))
         && muzzle_velocity == rom_vel(IDX_FIRST)))
        else $error("near clamp result differs from first point");

    a_far_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && range_status == STATUS_FAR) |->
        (aim_elevation == OUT_ELEV_W'(rom_elev(IDX_LAST))
         && muzzle_velocity == rom_vel(IDX_LAST)))
        else $error("far clamp result differs from last point");

    a_vel_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && range_status == STATUS_INTERP) |->
        (muzzle_velocity >= rom_vel(IDX_FIRST) && muzzle_velocity <= rom_vel(IDX_LAST)))
        else $error("interpolated velocity outside table range");

endmodule
